@@ rtl/modexp_pkg.sv @@
// ----------------------------------------------------------------------------
// modexp_pkg
// Control word layout, opcodes, branch selects and the microprogram of the
// modular exponentiation sequencer.
// ----------------------------------------------------------------------------
package modexp_pkg;

  typedef logic [3:0] upc_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RED,
    OP_INIT,
    OP_SETA,
    OP_MULA,
    OP_SETX,
    OP_MULX,
    OP_SHIFT,
    OP_OUT
  } op_t;

  // hold the step while the condition is true
  typedef enum logic [1:0] {
    H_NONE,
    H_NO_REQ,
    H_LOOP,
    H_OUT_BUSY
  } hold_t;

  // branch to target when the condition is true
  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_E_ZERO,
    J_BIT_CLR,
    J_EHI_ZERO
  } jump_t;

  typedef struct packed {
    op_t   op;
    hold_t hold_sel;
    jump_t jump_sel;
    upc_t  target;
  } ctrl_t;

  localparam upc_t S_IDLE  = 4'd0;
  localparam upc_t S_RED   = 4'd1;
  localparam upc_t S_INIT  = 4'd2;
  localparam upc_t S_TEST  = 4'd3;
  localparam upc_t S_MULA  = 4'd4;
  localparam upc_t S_SETX  = 4'd5;
  localparam upc_t S_MULX  = 4'd6;
  localparam upc_t S_SHIFT = 4'd7;
  localparam upc_t S_OUT   = 4'd8;

  localparam int PROG_LEN = 9;

  localparam ctrl_t PROGRAM [PROG_LEN] = '{
    '{op: OP_LOAD,  hold_sel: H_NO_REQ,   jump_sel: J_NONE,     target: S_IDLE},
    '{op: OP_RED,   hold_sel: H_LOOP,     jump_sel: J_NONE,     target: S_IDLE},
    '{op: OP_INIT,  hold_sel: H_NONE,     jump_sel: J_E_ZERO,   target: S_OUT},
    '{op: OP_SETA,  hold_sel: H_NONE,     jump_sel: J_BIT_CLR,  target: S_SETX},
    '{op: OP_MULA,  hold_sel: H_LOOP,     jump_sel: J_NONE,     target: S_IDLE},
    '{op: OP_SETX,  hold_sel: H_NONE,     jump_sel: J_EHI_ZERO, target: S_OUT},
    '{op: OP_MULX,  hold_sel: H_LOOP,     jump_sel: J_NONE,     target: S_IDLE},
    '{op: OP_SHIFT, hold_sel: H_NONE,     jump_sel: J_ALWAYS,   target: S_TEST},
    '{op: OP_OUT,   hold_sel: H_OUT_BUSY, jump_sel: J_ALWAYS,   target: S_IDLE}
  };

endpackage

@@ rtl/modexp_req_if.sv @@
// ----------------------------------------------------------------------------
// modexp_req_if
// Request channel: base and exponent with valid/ready.
// ----------------------------------------------------------------------------
interface modexp_req_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] exponent;

  modport source (output valid, output base, output exponent, input ready);
  modport sink   (input valid, input base, input exponent, output ready);
endinterface

@@ rtl/modexp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// modexp_rsp_if
// Result channel: power_mod with valid/ready.
// ----------------------------------------------------------------------------
interface modexp_rsp_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);
endinterface

@@ rtl/modular_exponentiation.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation
// Square-and-multiply modular exponentiation with bit-serial modular
// products, driven by a microprogram of nine control words.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   base, exponent
//   rsp      out  valid/ready   power_mod
//   cfg      in   cfg_we        cfg_wdata (modulus)
//
// A request runs the base reduction, then a multiply for each set exponent bit
// and a squaring for each bit below the highest set one; a zero exponent goes
// straight to the output. A clear exponent bit skips its multiply.
// The shift-add multiplier loop handles one bit per cycle.
// Synchronous reset clears the sequencer and sets the modulus to 0xFFFFFFFF.
// A new request is taken while a result waits in the output register; the
// sequencer stalls in its output step only if that register is still full.
// ----------------------------------------------------------------------------
module modular_exponentiation import modexp_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [WORD_BITS-1:0] cfg_wdata,
  modexp_req_if.sink           req,
  modexp_rsp_if.source         rsp
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);
  localparam logic [W-1:0]  MOD_RESET = W'(64'hFFFF_FFFF);
  localparam logic [W-1:0]  OUT_MASK  = W'(64'hFFFF_FFFF);
  localparam logic [W-1:0]  ONE       = W'(1);

  function automatic logic [W-1:0] add_mod(
    input logic [W-1:0] a,
    input logic [W-1:0] b,
    input logic [W-1:0] nn
  );
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (nn != '0 && s >= {1'b0, nn}) begin
      s = s - {1'b0, nn};
    end
    return s[W-1:0];
  endfunction

  logic [W-1:0]  n;
  logic [W-1:0]  r;
  logic [W-1:0]  bsh;
  logic [W-1:0]  e;
  logic [W-1:0]  acc;
  logic [W-1:0]  x;
  logic [W-1:0]  ma;
  logic [W-1:0]  mb;
  logic [W-1:0]  p;
  logic [CW-1:0] cnt;
  upc_t          upc;
  logic [W-1:0]  res;
  logic          out_valid;

  ctrl_t         cw;
  logic          hold;
  logic          jump;
  logic          exec;
  logic          cnt_last;
  logic          in_fire;
  logic [W-1:0]  p_next;
  logic [W-1:0]  ma_next;
  logic [W:0]    red_sh;
  logic [W-1:0]  r_next;
  upc_t          upc_next;

  assign cw       = PROGRAM[upc];
  assign cnt_last = (cnt == CNT_LAST);
  assign req.ready = (upc == S_IDLE);
  assign in_fire  = req.valid && req.ready;

  always_comb begin
    case (cw.hold_sel)
      H_NONE:     hold = 1'b0;
      H_NO_REQ:   hold = !req.valid;
      H_LOOP:     hold = !cnt_last;
      H_OUT_BUSY: hold = out_valid && !rsp.ready;
      default:    hold = 1'b0;
    endcase
  end

  always_comb begin
    case (cw.jump_sel)
      J_NONE:     jump = 1'b0;
      J_ALWAYS:   jump = 1'b1;
      J_E_ZERO:   jump = (e == '0);
      J_BIT_CLR:  jump = !e[0];
      J_EHI_ZERO: jump = (e[W-1:1] == '0);
      default:    jump = 1'b0;
    endcase
  end

  assign exec = (cw.hold_sel == H_LOOP) || !hold;

  always_comb begin
    if (hold) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + 4'd1;
    end
  end

  // one multiplier bit: conditional add and doubling, both modulo n
  assign p_next  = mb[0] ? add_mod(p, ma, n) : p;
  assign ma_next = add_mod(ma, ma, n);

  // one restoring remainder step on the base
  assign red_sh = {r, bsh[W-1]};
  assign r_next = (n != '0 && red_sh >= {1'b0, n}) ? W'(red_sh - {1'b0, n}) : red_sh[W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      n         <= MOD_RESET;
    end else begin
      upc <= upc_next;
      if (cfg_we) begin
        n <= cfg_wdata;
      end
      if (cw.hold_sel == H_LOOP) begin
        cnt <= cnt_last ? '0 : cnt + 1'b1;
      end
      if (exec && cw.op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      case (cw.op)
        OP_NOP: begin
        end
        OP_LOAD: begin
          bsh <= req.base;
          e   <= req.exponent;
          r   <= '0;
        end
        OP_RED: begin
          r   <= r_next;
          bsh <= {bsh[W-2:0], 1'b0};
        end
        OP_INIT: begin
          x <= r;
          if (e == '0) begin
            acc <= ONE;
          end else begin
            acc <= (n == ONE) ? '0 : ONE;
          end
        end
        OP_SETA: begin
          ma <= x;
          mb <= acc;
          p  <= '0;
        end
        OP_MULA: begin
          p  <= p_next;
          ma <= ma_next;
          mb <= {1'b0, mb[W-1:1]};
          if (cnt_last) begin
            acc <= p_next;
          end
        end
        OP_SETX: begin
          ma <= x;
          mb <= x;
          p  <= '0;
        end
        OP_MULX: begin
          p  <= p_next;
          ma <= ma_next;
          mb <= {1'b0, mb[W-1:1]};
          if (cnt_last) begin
            x <= p_next;
          end
        end
        OP_SHIFT: begin
          e <= {1'b0, e[W-1:1]};
        end
        OP_OUT: begin
          res <= acc & OUT_MASK;
        end
        default: begin
        end
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.power_mod = res;

  // a request always starts with the base reduction
  a_start_reduce: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> upc == S_RED)
    else $error("request did not start the reduction step");

  // the loop counter runs only inside a loop step
  a_cnt_in_loop: assert property (@(posedge clk) disable iff (rst)
    cnt != '0 |-> (upc == S_RED || upc == S_MULA || upc == S_MULX))
    else $error("loop counter active outside a loop step");

  // partial product stays reduced during a multiplication
  a_p_reduced: assert property (@(posedge clk) disable iff (rst)
    (upc == S_MULA || upc == S_MULX) |-> (n == '0 || p < n))
    else $error("partial product not reduced");

  // the output step waits while the previous result is not taken
  a_out_stall: assert property (@(posedge clk) disable iff (rst)
    (upc == S_OUT && out_valid && !rsp.ready) |=> upc == S_OUT)
    else $error("output step left while result register full");

endmodule
